// ----- sv/lqsm_pkg.sv -----
// ----------------------------------------------------------------------------
// lqsm_pkg
// Shared types and codes for the linear queue with search and max.
// ----------------------------------------------------------------------------
package lqsm_pkg;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } lqsm_state_t;

  typedef logic [2:0] req_t;
  localparam req_t REQ_ENQUEUE  = 3'd0;
  localparam req_t REQ_DEQUEUE  = 3'd1;
  localparam req_t REQ_PEEK     = 3'd2;
  localparam req_t REQ_SEARCH   = 3'd3;
  localparam req_t REQ_MAX      = 3'd4;
  localparam req_t REQ_TRAVERSE = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  localparam int CAP_BITS     = 5;
  localparam int CAP_RESET    = 16;
  localparam int SLOT_OUT_BITS = 4;

endpackage

// ----- sv/linear_queue_with_search_max_unit.sv -----
// ----------------------------------------------------------------------------
// linear_queue_with_search_max_unit
// Enqueue, and any defined request on an empty queue, gives its result in the
//   cycle after accept with busy staying low.
// Dequeue, peek, search, max and traverse walk the slot store one slot per
//   cycle through its registered read port, visiting at most STORE_DEPTH
//   slots; busy is high for the walk.
// Reset clears front and rear, sets the empty flag and sets capacity to 16;
//   the slot store is not cleared. Results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
module linear_queue_with_search_max_unit
  import lqsm_pkg::*;
#(
  parameter int STORE_DEPTH = 16,
  parameter int WORD_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_req_type,
  input  logic signed [WORD_BITS-1:0] in_operand_value,
  input  logic                        cfg_we,
  input  logic [CAP_BITS-1:0]         cfg_wdata,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic signed [WORD_BITS-1:0] out_data_word,
  output logic                        out_match_found,
  output logic [SLOT_OUT_BITS-1:0]    out_match_slot,
  output logic                        out_last_result
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = (AW + 1 > CAP_BITS) ? AW + 1 : CAP_BITS;

  lqsm_state_t state_r, state_nxt;

  logic signed [WORD_BITS-1:0] mem [STORE_DEPTH];
  logic signed [WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;

  logic [AW-1:0]               front_r, front_nxt;
  logic [AW-1:0]               rear_r, rear_nxt;
  logic                        empty_r, empty_nxt;
  logic [CAP_BITS-1:0]         cap_r;
  logic [AW-1:0]               cur_r, cur_nxt;
  logic                        first_r, first_nxt;
  logic signed [WORD_BITS-1:0] max_r, max_nxt;
  logic signed [WORD_BITS-1:0] key_r, key_nxt;
  req_t                        op_r, op_nxt;

  logic                        strobe_r, strobe_nxt;
  status_t                     status_r, status_nxt;
  logic signed [WORD_BITS-1:0] data_r, data_nxt;
  logic                        found_r, found_nxt;
  logic [SLOT_OUT_BITS-1:0]    slot_r, slot_nxt;
  logic                        last_r, last_nxt;

  logic                        accept;
  logic                        at_rear;
  logic                        walk_done;
  logic [CW-1:0]               cap_eff;
  logic                        full;
  logic signed [WORD_BITS-1:0] max_cand;
  logic [CW-1:0]               cur_ext;

  assign accept  = start && (state_r == S_IDLE);
  assign at_rear = (cur_r == rear_r);

  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end
    if (cap_eff > CW'(STORE_DEPTH)) begin
      cap_eff = CW'(STORE_DEPTH);
    end
  end

  assign full     = (CW'(rear_r) + CW'(1)) >= cap_eff;
  assign max_cand = (first_r || (rdata_r > max_r)) ? rdata_r : max_r;
  assign cur_ext  = CW'(cur_r);

  assign rd_addr = (state_r == S_WALK) ? cur_r + AW'(1) : front_r;
  assign wr_en   = accept && (in_req_type == REQ_ENQUEUE) && (empty_r || !full);
  assign wr_addr = empty_r ? '0 : rear_r + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_operand_value;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    walk_done = 1'b0;
    case (op_r)
      REQ_DEQUEUE, REQ_PEEK: walk_done = 1'b1;
      REQ_SEARCH:            walk_done = (rdata_r == key_r) || at_rear;
      REQ_MAX, REQ_TRAVERSE: walk_done = at_rear;
      default:               walk_done = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !empty_r &&
            (in_req_type == REQ_DEQUEUE || in_req_type == REQ_PEEK ||
             in_req_type == REQ_SEARCH || in_req_type == REQ_MAX ||
             in_req_type == REQ_TRAVERSE)) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    cur_nxt    = cur_r;
    first_nxt  = first_r;
    max_nxt    = max_r;
    key_nxt    = key_r;
    op_nxt     = op_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    data_nxt   = '0;
    found_nxt  = 1'b0;
    slot_nxt   = '0;
    last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_req_type;
          key_nxt   = in_operand_value;
          cur_nxt   = front_r;
          first_nxt = 1'b1;
          case (in_req_type)
            REQ_ENQUEUE: begin
              strobe_nxt = 1'b1;
              if (empty_r) begin
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b0;
              end else if (full) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                rear_nxt = rear_r + AW'(1);
              end
            end
            REQ_DEQUEUE, REQ_PEEK, REQ_MAX, REQ_TRAVERSE: begin
              if (empty_r) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_EMPTY;
              end
            end
            REQ_SEARCH: begin
              if (empty_r) begin
                strobe_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cur_nxt   = cur_r + AW'(1);
        first_nxt = 1'b0;
        max_nxt   = max_cand;
        case (op_r)
          REQ_DEQUEUE, REQ_PEEK: begin
            strobe_nxt = 1'b1;
            data_nxt   = rdata_r;
            if (op_r == REQ_DEQUEUE) begin
              if (front_r == rear_r) begin
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b1;
              end else begin
                front_nxt = front_r + AW'(1);
              end
            end
          end
          REQ_SEARCH: begin
            if (rdata_r == key_r) begin
              strobe_nxt = 1'b1;
              found_nxt  = 1'b1;
              slot_nxt   = cur_ext[SLOT_OUT_BITS-1:0];
            end else if (at_rear) begin
              strobe_nxt = 1'b1;
            end
          end
          REQ_MAX: begin
            if (at_rear) begin
              strobe_nxt = 1'b1;
              data_nxt   = max_cand;
            end
          end
          REQ_TRAVERSE: begin
            strobe_nxt = 1'b1;
            data_nxt   = rdata_r;
            last_nxt   = at_rear;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= '0;
      rear_r   <= '0;
      empty_r  <= 1'b1;
      cap_r    <= CAP_BITS'(CAP_RESET);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      rear_r   <= rear_nxt;
      empty_r  <= empty_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    first_r  <= first_nxt;
    max_r    <= max_nxt;
    key_r    <= key_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    found_r  <= found_nxt;
    slot_r   <= slot_nxt;
    last_r   <= last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_data_word   = data_r;
  assign out_match_found = found_r;
  assign out_match_slot  = slot_r;
  assign out_last_result = last_r;

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_r == '0) && (rear_r == '0))
    else $error("empty queue with nonzero ends");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> front_r <= rear_r)
    else $error("front beyond rear");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !empty_r && (cur_r >= front_r) && (cur_r <= rear_r))
    else $error("walk index outside queue");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && (state_nxt == S_IDLE) |=> out_strobe && out_last_result)
    else $error("walk ended without final item");

endmodule
